/* hw/rtl/decimal_formatter_grouped_macros.svh */
// Assertion macros for the grouped decimal formatter.
// Each macro expects clk_i and rst_ni in the scope of its use.
`ifndef DECIMAL_FORMATTER_GROUPED_MACROS_SVH
`define DECIMAL_FORMATTER_GROUPED_MACROS_SVH
`ifndef SYNTHESIS
`define DFG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define DFG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DFG_ASSERT_IMP(lbl, ante, cons, msg)
`define DFG_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* hw/rtl/dfg_pkg.sv */
// ----------------------------------------------------------------------------
// dfg_pkg
// Constants and helpers for the grouped decimal formatter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package dfg_pkg;

  localparam int unsigned ValW       = 64;
  localparam int unsigned Digits     = 20;
  localparam int unsigned BcdW       = 4 * Digits;
  localparam int unsigned DdW        = BcdW + ValW;
  localparam int unsigned StepsStage = 8;
  localparam int unsigned NumStages  = ValW / StepsStage;
  localparam int unsigned PosW       = 5;
  localparam int unsigned CharW      = 6;

  localparam logic [CharW-1:0] CharSpace = 6'd32;
  localparam logic [CharW-1:0] CharZero  = 6'd48;

  typedef logic [DdW-1:0] dd_t;

  // Run StepsStage shift-and-add-3 steps of the binary to BCD conversion.
  function automatic dd_t dd_steps(input dd_t x);
    dd_t y;
    y = x;
    for (int s = 0; s < StepsStage; s++) begin
      for (int d = 0; d < Digits; d++) begin
        if (y[ValW + 4*d +: 4] >= 4'd5) begin
          y[ValW + 4*d +: 4] = y[ValW + 4*d +: 4] + 4'd3;
        end
      end
      y = {y[DdW-2:0], 1'b0};
    end
    return y;
  endfunction

  // True where a separator follows the digit at this position.
  function automatic logic grp_start(input logic [PosW-1:0] pos);
    return (pos == 5'd3) || (pos == 5'd6) || (pos == 5'd9) ||
           (pos == 5'd12) || (pos == 5'd15) || (pos == 5'd18);
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/decimal_formatter_grouped.sv */
// ----------------------------------------------------------------------------
// decimal_formatter_grouped
// Converts a 64-bit unsigned value to grouped decimal ASCII text.
// ----------------------------------------------------------------------------
// Pipeline: 8 conversion stages (8 shift-add-3 steps each), then the
// character serializer registers the digits and emits the first character.
// Output: one char per cycle while m_axis_tready is high; a value gives 2 to 27
// characters (lead space, digits, separators), set by the character serializer.
// Reset: asynchronous active low; clears all valid bits and serializer state.
`timescale 1ns / 1ps
`default_nettype none
`include "decimal_formatter_grouped_macros.svh"
module decimal_formatter_grouped (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [dfg_pkg::ValW-1:0]   s_axis_tdata,  // [63:0] value
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // [5:0] text_char, [7:6] zero
  output logic                            m_axis_tlast   // last_char
);
  import dfg_pkg::*;

  dd_t                  dd_q [NumStages];
  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;
  dd_t                  dd_in [NumStages];

  logic                 busy_q, busy_d;
  logic                 space_q, space_d;
  logic [PosW-1:0]      pos_q, pos_d;
  logic [BcdW-1:0]      bcd_q;
  logic                 ser_can, ser_load, out_last, out_fire;
  logic [PosW-1:0]      top_pos;
  logic [3:0]           cur_digit;
  logic [CharW-1:0]     out_char;

  // Advance enables: a stage moves when empty or its successor moves.
  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || ser_can;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end
  assign s_axis_tready = en[0];

  // Stage inputs.
  always_comb begin
    dd_in[0] = {{BcdW{1'b0}}, s_axis_tdata};
    for (int k = 1; k < NumStages; k++) begin
      dd_in[k] = dd_q[k-1];
    end
  end

  // Conversion pipeline valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Conversion pipeline data.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumStages; k++) begin
      if (en[k]) begin
        dd_q[k] <= dd_steps(dd_in[k]);
      end
    end
  end

  // Find the most significant nonzero digit.
  always_comb begin
    top_pos = '0;
    for (int d = 0; d < Digits; d++) begin
      if (dd_q[NumStages-1][ValW + 4*d +: 4] != 4'd0) begin
        top_pos = PosW'(d);
      end
    end
  end

  // Serializer output.
  assign cur_digit     = bcd_q[4*pos_q +: 4];
  assign out_last      = !space_q && (pos_q == '0);
  assign out_char      = space_q ? CharSpace : (CharZero + {2'b00, cur_digit});
  assign out_fire      = busy_q && m_axis_tready;
  assign ser_can       = !busy_q || (m_axis_tready && out_last);
  assign ser_load      = v_q[NumStages-1] && ser_can;
  assign m_axis_tvalid = busy_q;
  assign m_axis_tdata  = {2'b00, out_char};
  assign m_axis_tlast  = out_last;

  // Step through lead space, digits and separators.
  always_comb begin
    busy_d  = busy_q;
    space_d = space_q;
    pos_d   = pos_q;
    if (ser_load) begin
      busy_d  = 1'b1;
      space_d = 1'b1;
      pos_d   = top_pos;
    end else if (out_fire) begin
      if (out_last) begin
        busy_d = 1'b0;
      end else if (space_q) begin
        space_d = 1'b0;
      end else begin
        space_d = grp_start(pos_q);
        pos_d   = pos_q - 1'b1;
      end
    end
  end

  // Hold serializer control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      space_q <= 1'b0;
      pos_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      space_q <= space_d;
      pos_q   <= pos_d;
    end
  end

  // Hold the digits of the value in flight.
  always_ff @(posedge clk_i) begin
    if (ser_load) begin
      bcd_q <= dd_q[NumStages-1][DdW-1:ValW];
    end
  end

  `DFG_ASSERT_IMP(a_last_is_digit, m_axis_tvalid && m_axis_tlast, !space_q, "last char is a space")
  `DFG_ASSERT_IMP(a_digit_range, busy_q && !space_q, cur_digit <= 4'd9, "digit out of range")
  `DFG_ASSERT_IMP(a_stall_full, !s_axis_tready, v_q[0], "input stalled with empty first stage")
  `DFG_ASSERT_NXT(a_load_space, ser_load, busy_q && space_q, "run does not open with space")

endmodule
`default_nettype wire

/* tb/dfg_checker.sv */
// ----------------------------------------------------------------------------
// dfg_checker
// Watches both stream channels, builds the expected grouped decimal text for
// every accepted value and compares each emitted character in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dfg_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  input  wire logic        s_tready_i,
  input  wire logic [63:0] s_tdata_i,   // [63:0] value
  input  wire logic        m_tvalid_i,
  input  wire logic        m_tready_i,
  input  wire logic [7:0]  m_tdata_i,   // [5:0] text_char, [7:6] zero
  input  wire logic        m_tlast_i,   // last_char
  output int               errors_o,
  output int               pending_o
);

  typedef struct packed {
    logic [5:0] text_char;
    logic       last_char;
  } char_t;

  char_t char_q[$];

  // Queue the text of one value: lead space, digits with group separators.
  task automatic push_text(input logic [63:0] value);
    logic [3:0]  digs [20];
    logic [63:0] n;
    int          cnt;
    char_t       c;
    n   = value;
    cnt = 0;
    do begin
      digs[cnt] = 4'(n % 10);
      n = n / 10;
      cnt++;
    end while (n != 0 && cnt < 20);
    c.text_char = dfg_pkg::CharSpace;
    c.last_char = 1'b0;
    char_q.push_back(c);
    for (int p = cnt - 1; p >= 0; p--) begin
      c.text_char = dfg_pkg::CharZero + 6'(digs[p]);
      c.last_char = (p == 0);
      char_q.push_back(c);
      if (p > 0 && p % 3 == 0) begin
        c.text_char = dfg_pkg::CharSpace;
        c.last_char = 1'b0;
        char_q.push_back(c);
      end
    end
  endtask

  // Predict on input requests, compare on output requests.
  always @(posedge clk_i) begin
    char_t exp_c;
    int    err_n;
    err_n = 0;
    if (!rst_ni) begin
      errors_o <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i) push_text(s_tdata_i);
      if (m_tvalid_i && m_tready_i) begin
        if (char_q.size() == 0) begin
          $error("unexpected char: tdata=%0d tlast=%0d", m_tdata_i, m_tlast_i);
          err_n++;
        end else begin
          exp_c = char_q.pop_front();
          if (m_tdata_i !== {2'b00, exp_c.text_char}) begin
            $error("text_char: expected %0d actual %0d", exp_c.text_char, m_tdata_i);
            err_n++;
          end
          if (m_tlast_i !== exp_c.last_char) begin
            $error("last_char: expected %0d actual %0d", exp_c.last_char, m_tlast_i);
            err_n++;
          end
        end
      end
      if (err_n != 0) errors_o <= errors_o + err_n;
    end
    pending_o <= char_q.size();
  end

endmodule
`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives directed and random 64-bit values into the grouped decimal
// formatter with random gaps and stalls, and reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb;

  localparam int NumRandom = 450;
  localparam int StallLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // [63:0] value
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [5:0] text_char, [7:6] zero
  logic        m_axis_tlast;        // last_char
  int          errors;
  int          pending;
  int          idle_cycles = 0;
  logic [63:0] value_list[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  decimal_formatter_grouped u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  dfg_checker u_checker (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready), .s_tdata_i(s_axis_tdata),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_tdata_i(m_axis_tdata),
    .m_tlast_i(m_axis_tlast), .errors_o(errors), .pending_o(pending)
  );

  // Mostly short gaps, now and then a long one, often none.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Random value of random decimal length, with some pure random bits.
  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    int          k;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return v;
      1: return v % 1000;
      default: begin
        k = $urandom_range(1, 63);
        return v >> k;
      end
    endcase
  endfunction

  // Receiver: stall at random.
  always @(posedge clk_i) begin
    if ($urandom_range(0, 99) < 30) m_axis_tready <= 1'b0;
    else m_axis_tready <= 1'b1;
  end

  // Watchdog on cycles without any request.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int g;
    value_list = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100, 64'd999, 64'd1000,
                   64'd9999, 64'd12345, 64'd100000, 64'd999999, 64'd1000000,
                   64'd1234567890, 64'd10000000000000000000, 64'hFFFFFFFFFFFFFFFF,
                   64'h8000000000000000, 64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA,
                   64'd999999999999999999, 64'd1000000000000000000};
    for (int i = 0; i < NumRandom; i++) value_list.push_back(rand_value());
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Send each value, hold until accepted, then idle for a random gap.
    foreach (value_list[i]) begin
      g = gap_len();
      if (g > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= value_list[i];
      do @(posedge clk_i); while (!s_axis_tready);
    end
    s_axis_tvalid <= 1'b0;
    // Let the checker count the last request before draining.
    @(posedge clk_i);
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* decimal_formatter_grouped.f */
+incdir+hw/rtl
hw/rtl/dfg_pkg.sv
hw/rtl/decimal_formatter_grouped.sv
tb/dfg_checker.sv
tb/tb.sv
